FILE: hdl/pcxd_pkg.sv
// ----------------------------------------------------------------------------
// pcxd_pkg: shared types and constants of the PCX run-length pixel decoder
// Command and status bundles between controller and datapath, mode codes,
// register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pcxd_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_BYTES_PER_LINE = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd2;
  localparam logic [1:0] REG_PIXEL_MODE     = 2'd3;

  // Pixel modes
  localparam logic [1:0] MODE_PAL8  = 2'd0;
  localparam logic [1:0] MODE_RGB8  = 2'd1;
  localparam logic [1:0] MODE_MONO1 = 2'd2;
  localparam logic [1:0] MODE_PLN4  = 2'd3;

  // Opcodes carried on tuser
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  // Run marker: top two bits set, low six bits the count
  localparam logic [7:0] RUN_MARK   = 8'hC0;
  localparam logic [5:0] COUNT_MASK = 6'h3F;
  localparam logic [2:0] TOP_BIT    = 3'd7;

  // Limits on register values
  localparam int unsigned MAX_WIDTH  = 8192;
  localparam int unsigned MAX_HEIGHT = 65536;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 232;

  typedef struct packed {
    logic load;     // input beat accepted
    logic put;      // store a non-final plane byte and advance
    logic skip;     // final plane byte without visible pixel: advance
    logic rd;       // start pixel assembly, read line stores
    logic pal_rd;   // read palette for current pixel
    logic pal_cap;  // capture current pixel
    logic commit;   // move assembly to output register and advance
    logic drain;    // held result taken by receiver
  } cmd_t;

  typedef struct packed {
    logic start_run;  // accepted data beat begins decoded output
    logic run_done;   // repeat count exhausted or height reached
    logic is_store;   // current plane is not the last
    logic visible;    // current byte has a visible pixel
    logic k_last;     // current pixel is the last of the result
    logic held;       // output register holds an unsent result
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/pcxd_ram.sv
// ----------------------------------------------------------------------------
// pcxd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pcxd_ctrl.sv
// ----------------------------------------------------------------------------
// pcxd_ctrl: decoder sequencer
// Steps through the decoded bytes of a run, one pixel at a time, and
// handles the output handshake with a one-result hold for the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_ctrl
  import pcxd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output logic      out_last_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_STEP = 3'd1;
  localparam logic [2:0] ST_PAL  = 3'd2;
  localparam logic [2:0] ST_PALW = 3'd3;
  localparam logic [2:0] ST_ASM  = 3'd4;
  localparam logic [2:0] ST_SEND = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SEND) || (state_q == ST_FIN && sts_i.held);
  assign out_last_o  = (state_q == ST_FIN);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.start_run) state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts_i.run_done) begin
          state_d = ST_FIN;
        end else if (sts_i.is_store) begin
          cmd_o.put = 1'b1;
        end else if (!sts_i.visible) begin
          cmd_o.skip = 1'b1;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_PAL;
        end
      end
      ST_PAL: begin
        cmd_o.pal_rd = 1'b1;
        state_d      = ST_PALW;
      end
      ST_PALW: begin
        cmd_o.pal_cap = 1'b1;
        state_d       = sts_i.k_last ? ST_ASM : ST_PAL;
      end
      ST_ASM: begin
        if (sts_i.held) begin
          state_d = ST_SEND;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = ST_STEP;
        end
      end
      ST_SEND: begin
        // earlier result goes out without last, then this one is held
        if (out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_STEP;
        end
      end
      ST_FIN: begin
        if (!sts_i.held) begin
          state_d = ST_IDLE;
        end else if (out_ready_i) begin
          cmd_o.drain = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pcxd_datapath.sv
// ----------------------------------------------------------------------------
// pcxd_datapath: run state, line stores, palette and pixel assembly
// Holds configuration, decoding position, plane line stores, palette RAM
// and the output result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_datapath
  import pcxd_pkg::*;
#(
  parameter int unsigned MAX_BYTES_PER_LINE = 1024,
  parameter int unsigned STORED_PLANES      = 3,
  parameter int unsigned PALETTE_ENTRIES    = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [16:0]           cfg_data_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire logic                  in_user_i,
  output logic [OUT_DATA_W-1:0]      out_data_o,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o
);

  localparam int unsigned PW = $clog2(MAX_BYTES_PER_LINE);
  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  // configuration
  logic [10:0] bpl_q;
  logic [13:0] width_q;
  logic [16:0] height_q;
  logic [1:0]  mode_q;

  // decoding state
  logic          awaiting_q;
  logic [5:0]    pending_q;
  logic [5:0]    rep_q;
  logic [1:0]    plane_q;
  logic [PW-1:0] pos_q;
  logic [16:0]   line_q;
  logic [7:0]    byte_q;

  // assembly
  logic [2:0]  k_q;
  logic [12:0] first_q;
  logic [15:0] aline_q;
  logic [3:0]  cnt_q;
  logic [23:0] pix_q [8];
  logic        oob_q;
  logic        held_q;
  logic [OUT_DATA_W-1:0] out_q;

  logic [7:0]  in_byte;
  logic [7:0]  in_pidx;
  logic [23:0] in_pcol;
  assign in_byte = in_data_i[7:0];
  assign in_pidx = in_data_i[15:8];
  assign in_pcol = in_data_i[39:16];

  // effective register values
  logic [14:0] bpl_w, bpl_eff;
  logic [13:0] width_eff;
  logic [16:0] height_eff;
  logic [1:0]  last_plane, plane_eff;
  logic        wide, at_height;

  always_comb begin
    bpl_w   = (bpl_q == 11'd0) ? 15'd1 : 15'(bpl_q);
    bpl_eff = (bpl_w > 15'(MAX_BYTES_PER_LINE)) ? 15'(MAX_BYTES_PER_LINE) : bpl_w;
    width_eff  = (width_q > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : width_q;
    height_eff = (height_q > 17'(MAX_HEIGHT)) ? 17'(MAX_HEIGHT) : height_q;
    case (mode_q)
      MODE_RGB8: last_plane = 2'd2;
      MODE_PLN4: last_plane = 2'd3;
      default:   last_plane = 2'd0;
    endcase
    plane_eff = (plane_q > last_plane) ? last_plane : plane_q;
    wide      = (mode_q == MODE_MONO1) || (mode_q == MODE_PLN4);
    at_height = (line_q >= height_eff);
  end

  // position of first pixel and pixel count
  logic [16:0] first_w, rem_w;
  logic [3:0]  cnt_w;
  logic        visible;
  always_comb begin
    first_w = wide ? (17'(pos_q) << 3) : 17'(pos_q);
    visible = first_w < 17'(width_eff);
    rem_w   = 17'(width_eff) - first_w;
    if (!wide)             cnt_w = 4'd1;
    else if (rem_w > 17'd8) cnt_w = 4'd8;
    else                   cnt_w = rem_w[3:0];
  end

  // advance to the next byte position
  logic [14:0]   pos_nx;
  logic          advance;
  assign pos_nx  = 15'(pos_q) + 15'd1;
  assign advance = cmd_i.put || cmd_i.skip || cmd_i.commit;

  // line stores, one RAM per stored plane, all read at the same position
  logic [7:0] st_rd [3];
  for (genvar j = 0; j < 3; j++) begin : g_plane
    if (j < STORED_PLANES) begin : g_ram
      pcxd_ram #(
        .WIDTH(8),
        .DEPTH(MAX_BYTES_PER_LINE)
      ) u_store (
        .clk_i  (clk_i),
        .we_i   (cmd_i.put && plane_eff == 2'(j)),
        .waddr_i(pos_q),
        .wdata_i(byte_q),
        .re_i   (cmd_i.rd),
        .raddr_i(pos_q),
        .rdata_o(st_rd[j])
      );
    end else begin : g_zero
      assign st_rd[j] = 8'd0;
    end
  end

  // palette index of the current pixel
  logic [2:0] sh;
  logic [7:0] pidx;
  logic       p_oob;
  always_comb begin
    sh = TOP_BIT - k_q;
    case (mode_q)
      MODE_PAL8:  pidx = byte_q;
      MODE_MONO1: pidx = {7'd0, byte_q[sh]};
      MODE_PLN4:  pidx = {4'd0, byte_q[sh], st_rd[2][sh], st_rd[1][sh], st_rd[0][sh]};
      default:    pidx = 8'd0;
    endcase
    p_oob = {1'b0, pidx} >= 9'(PALETTE_ENTRIES);
  end

  logic [23:0] pal_rd;
  pcxd_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load && in_user_i == OP_PALETTE &&
             {1'b0, in_pidx} < 9'(PALETTE_ENTRIES)),
    .waddr_i(in_pidx[AW-1:0]),
    .wdata_i(in_pcol),
    .re_i   (cmd_i.pal_rd),
    .raddr_i(pidx[AW-1:0]),
    .rdata_o(pal_rd)
  );

  logic [23:0] pix_rgb;
  assign pix_rgb = (mode_q == MODE_RGB8) ? {st_rd[0], st_rd[1], byte_q} :
                   (oob_q ? 24'd0 : pal_rd);

  // status
  always_comb begin
    sts_o.start_run = in_user_i == OP_DATA && !at_height &&
                      (awaiting_q || (in_byte & RUN_MARK) != RUN_MARK);
    sts_o.run_done  = (rep_q == 6'd0) || at_height;
    sts_o.is_store  = plane_eff < last_plane;
    sts_o.visible   = visible;
    sts_o.k_last    = ({1'b0, k_q} + 4'd1) == cnt_q;
    sts_o.held      = held_q;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpl_q    <= 11'd1;
      width_q  <= 14'd1;
      height_q <= 17'd1;
      mode_q   <= MODE_PAL8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BYTES_PER_LINE: bpl_q    <= cfg_data_i[10:0];
        REG_IMAGE_WIDTH:    width_q  <= cfg_data_i[13:0];
        REG_IMAGE_HEIGHT:   height_q <= cfg_data_i;
        REG_PIXEL_MODE:     mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // run state and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      pending_q  <= 6'd0;
      rep_q      <= 6'd0;
      plane_q    <= 2'd0;
      pos_q      <= '0;
      line_q     <= 17'd0;
      held_q     <= 1'b0;
    end else begin
      if (cmd_i.load && in_user_i == OP_DATA && !at_height) begin
        if (awaiting_q) begin
          rep_q      <= pending_q;
          awaiting_q <= 1'b0;
          pending_q  <= 6'd0;
        end else if ((in_byte & RUN_MARK) == RUN_MARK) begin
          awaiting_q <= 1'b1;
          pending_q  <= in_byte[5:0] & COUNT_MASK;
        end else begin
          rep_q <= 6'd1;
        end
      end
      if (advance) begin
        rep_q <= rep_q - 6'd1;
        if (pos_nx >= bpl_eff) begin
          pos_q <= '0;
          if (plane_eff == last_plane) begin
            plane_q <= 2'd0;
            line_q  <= line_q + 17'd1;
          end else begin
            plane_q <= plane_eff + 2'd1;
          end
        end else begin
          pos_q <= pos_nx[PW-1:0];
        end
      end
      if (cmd_i.commit) held_q <= 1'b1;
      else if (cmd_i.drain) held_q <= 1'b0;
    end
  end

  // pixel counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 3'd0;
    end else if (cmd_i.rd) begin
      k_q <= 3'd0;
    end else if (cmd_i.pal_cap) begin
      k_q <= k_q + 3'd1;
    end
  end

  // assembly and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) byte_q <= in_byte;
    if (cmd_i.rd) begin
      first_q <= first_w[12:0];
      aline_q <= line_q[15:0];
      cnt_q   <= cnt_w;
      for (int i = 0; i < 8; i++) pix_q[i] <= 24'd0;
    end
    if (cmd_i.pal_rd) oob_q <= p_oob;
    if (cmd_i.pal_cap) pix_q[k_q] <= pix_rgb;
    if (cmd_i.commit) begin
      out_q <= {7'd0, pix_q[7], pix_q[6], pix_q[5], pix_q[4], pix_q[3], pix_q[2],
                pix_q[1], pix_q[0], cnt_q, aline_q, first_q};
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: hdl/pcx_rle_planar_pixel_decoder_top.sv
// ----------------------------------------------------------------------------
// pcx_rle_planar_pixel_decoder_top: PCX run-length decoder with pixel output
// Input beats carry encoded image bytes or palette writes (tuser selects).
// A run marker byte (top two bits set) repeats the next byte 0 to 63 times.
// Decoded bytes fill per-plane line stores; bytes of the last plane give
// one output beat of up to eight packed RGB pixels. tlast marks the final
// beat caused by one input beat.
// Configuration: write bytes_per_line, image_width, image_height and
// pixel_mode on the cfg channel while the block is idle; cfg_ready_o is
// always high.
// Sequence: the input beat is taken while idle; a run then handles each
// byte that is only stored or has no visible pixel with one put or skip,
// and each byte giving N pixels by a line store read, one palette read and
// one capture per pixel, then a commit, waiting for the receiver once a
// result is held. A run ends in a final state that sends any held beat.
// Results leave through an output register; one result is held back until
// the next is formed or the run ends, to set tlast. A stalled receiver
// stalls the sequencer and with it the input. Reset clears the decoding
// state and registers; line stores and palette need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_planar_pixel_decoder_top
  import pcxd_pkg::*;
#(
  parameter int unsigned MAX_BYTES_PER_LINE = 1024,
  parameter int unsigned STORED_PLANES      = 3,
  parameter int unsigned PALETTE_ENTRIES    = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [16:0]           cfg_data_i,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: data_byte[7:0], palette_index[15:8], palette_color[39:16]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: opcode
  input  wire logic                  s_axis_tuser,
  // output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: first_pixel_x[12:0], line_number[28:13], pixel_count[32:29],
  // pixel0_rgb..pixel7_rgb at 24 bits each from bit 33, zero pad above
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // tlast: last_of_run
  output logic                       m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  pcxd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_last_o (m_axis_tlast),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcxd_datapath #(
    .MAX_BYTES_PER_LINE(MAX_BYTES_PER_LINE),
    .STORED_PLANES     (STORED_PLANES),
    .PALETTE_ENTRIES   (PALETTE_ENTRIES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the PCX run-length planar pixel decoder
// Drives encoded bytes and palette writes on the input stream, predicts each
// output beat from its own model of the decoder and compares field by field.
// Runs several register settings with random gaps on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import pcxd_pkg::*;

  localparam int unsigned LINE_BYTES = 1024;
  localparam int unsigned PLANES_KEPT = 3;
  localparam int unsigned PAL_SIZE = 256;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 300;

  typedef struct {
    logic [OUT_DATA_W-1:0] data;
    logic                  last;
  } pixel_beat_t;

  // Decoder model and store of expected pixel beats
  class pixel_scoreboard;
    int unsigned bpl, width, height;
    logic [1:0]  mode;
    bit          await_value;
    int unsigned run_count, plane_pos, byte_pos, line_no;
    logic [7:0]  line_store [PLANES_KEPT*LINE_BYTES];
    logic [23:0] palette [PAL_SIZE];
    pixel_beat_t pending [$];
    int unsigned errors;

    function new();
      bpl = 1; width = 1; height = 1; mode = MODE_PAL8;
      await_value = 0; run_count = 0; plane_pos = 0; byte_pos = 0; line_no = 0;
      errors = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    function void set_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        REG_BYTES_PER_LINE: bpl = val[10:0];
        REG_IMAGE_WIDTH:    width = val[13:0];
        REG_IMAGE_HEIGHT:   height = val;
        REG_PIXEL_MODE:     mode = val[1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] stored(int unsigned pl, int unsigned pos);
      if (pl >= PLANES_KEPT || pos >= LINE_BYTES) return 8'h00;
      return line_store[pl*LINE_BYTES + pos];
    endfunction

    // One decoded byte; returns 1 when a pixel beat was queued
    function bit decode_byte(logic [7:0] v);
      int unsigned lim_bpl, lim_w, last_pl, pl, pos, first, cnt;
      logic [OUT_DATA_W-1:0] d;
      logic [23:0] rgb;
      logic [3:0]  col;
      logic [7:0]  s0, s1, s2;
      pixel_beat_t b;
      bit made;
      made = 0;
      lim_bpl = (bpl == 0) ? 1 : ((bpl > LINE_BYTES) ? LINE_BYTES : bpl);
      lim_w = (width > MAX_WIDTH) ? MAX_WIDTH : width;
      last_pl = (mode == MODE_RGB8) ? 2 : ((mode == MODE_PLN4) ? 3 : 0);
      pl = (plane_pos > last_pl) ? last_pl : plane_pos;
      pos = byte_pos;
      if (pl < last_pl) begin
        if (pl < PLANES_KEPT && pos < LINE_BYTES) line_store[pl*LINE_BYTES + pos] = v;
      end else begin
        first = (mode >= MODE_MONO1) ? pos * 8 : pos;
        if (first < lim_w) begin
          cnt = (mode >= MODE_MONO1) ? ((lim_w - first > 8) ? 8 : lim_w - first) : 1;
          s0 = stored(0, pos);
          s1 = stored(1, pos);
          s2 = stored(2, pos);
          d = '0;
          for (int k = 0; k < cnt; k++) begin
            case (mode)
              MODE_PAL8: rgb = palette[v];
              MODE_RGB8: rgb = {s0, s1, v};
              MODE_MONO1: rgb = palette[{7'd0, v[7-k]}];
              default: begin
                col = {v[7-k], s2[7-k], s1[7-k], s0[7-k]};
                rgb = palette[{4'd0, col}];
              end
            endcase
            d[33 + 24*k +: 24] = rgb;
          end
          d[12:0] = first[12:0];
          d[28:13] = line_no[15:0];
          d[32:29] = cnt[3:0];
          b.data = d;
          b.last = 0;
          pending.push_back(b);
          made = 1;
        end
      end
      pos++;
      if (pos >= lim_bpl) begin
        pos = 0;
        pl++;
        if (pl > last_pl) begin
          pl = 0;
          line_no++;
        end
      end
      byte_pos = pos;
      plane_pos = pl;
      return made;
    endfunction

    // Accepted input beat
    function void note_input(logic op, logic [39:0] d);
      int unsigned lim_h, rep, n;
      logic [7:0] v;
      v = d[7:0];
      n = 0;
      if (op == OP_PALETTE) begin
        palette[d[15:8]] = d[39:16];
        return;
      end
      lim_h = (height > MAX_HEIGHT) ? MAX_HEIGHT : height;
      if (line_no >= lim_h) return;
      if (await_value) begin
        rep = run_count;
        await_value = 0;
        run_count = 0;
      end else if ((v & RUN_MARK) == RUN_MARK) begin
        await_value = 1;
        run_count = v & COUNT_MASK;
        return;
      end else begin
        rep = 1;
      end
      for (int r = 0; r < rep; r++) begin
        if (line_no >= lim_h) break;
        n += decode_byte(v);
      end
      if (n > 0) pending[$].last = 1;
    endfunction

    // Accepted output beat against the oldest expectation
    task check_result(logic [OUT_DATA_W-1:0] d, logic last);
      pixel_beat_t w;
      if (pending.size() == 0) begin
        report("unexpected beat x", 32'(d[12:0]), 32'd0);
        return;
      end
      w = pending.pop_front();
      if (d[12:0] !== w.data[12:0])
        report("first_pixel_x", 32'(d[12:0]), 32'(w.data[12:0]));
      if (d[28:13] !== w.data[28:13])
        report("line_number", 32'(d[28:13]), 32'(w.data[28:13]));
      if (d[32:29] !== w.data[32:29])
        report("pixel_count", 32'(d[32:29]), 32'(w.data[32:29]));
      for (int k = 0; k < 8; k++)
        if (d[33 + 24*k +: 24] !== w.data[33 + 24*k +: 24])
          report($sformatf("pixel%0d_rgb", k), 32'(d[33 + 24*k +: 24]),
                 32'(w.data[33 + 24*k +: 24]));
      if (last !== w.last) report("last_of_run", 32'(last), 32'(w.last));
    endtask
  endclass

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_valid_i = 0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i = '0;
  logic [16:0]           cfg_data_i = '0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  pixel_scoreboard sb = new();
  bit          hold_req = 0;
  bit          quiet = 0;
  int unsigned idle_cycles = 0;

  pcx_rle_planar_pixel_decoder_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // Receiver readiness, with one long hold-off on request
  always @(posedge clk_i) begin
    int unsigned wait_left;
    if (hold_req) begin
      hold_req <= 0;
      m_axis_tready <= 0;
      repeat (400) @(posedge clk_i);
    end
    wait_left = pick_gap();
    if (wait_left > 0) begin
      m_axis_tready <= 0;
      repeat (wait_left) @(posedge clk_i);
    end
    m_axis_tready <= 1;
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_config(int unsigned bpl, int unsigned w, int unsigned h,
                              logic [1:0] mode);
    logic [16:0] vals [4];
    vals[0] = 17'(bpl); vals[1] = 17'(w); vals[2] = 17'(h); vals[3] = 17'(mode);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1;
      cfg_index_i <= i[1:0];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(i[1:0], vals[i]);
    end
    cfg_valid_i <= 0;
  endtask

  task automatic send_beat(logic op, logic [39:0] d);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, d);
    if ($urandom_range(0, 15) == 0) quiet = ~quiet;
  endtask

  // Data beat with random junk in the palette fields
  task automatic send_byte(logic [7:0] b);
    send_beat(OP_DATA, {24'($urandom), 8'($urandom), b});
  endtask

  task automatic send_palette(logic [7:0] idx, logic [23:0] rgb);
    send_beat(OP_PALETTE, {rgb, idx, 8'($urandom)});
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed literals and runs, some palette writes and raw noise;
  // with low set every decoded byte stays within the written palette entries
  task automatic random_items(int unsigned n, bit low);
    int unsigned r, cnt;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_palette(8'($urandom), 24'($urandom));
      end else if (r < 55) begin
        send_byte(low ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 8'hBF)));
      end else if (r < 88) begin
        cnt = $urandom_range(0, 9);
        cnt = (cnt == 9) ? 63 : ((cnt == 8) ? 0 : $urandom_range(1, 6));
        send_byte(RUN_MARK | 8'(cnt));
        send_byte(low ? 8'($urandom_range(0, 15)) : 8'($urandom));
      end else begin
        send_byte(low ? 8'($urandom_range(0, 15)) : 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] extra_idx [5];
    extra_idx = '{8'h12, 8'h3F, 8'h80, 8'hBF, 8'hFF};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Palette entries read later: the low sixteen and the directed values
    for (int i = 0; i < 16; i++) send_palette(i[7:0], 24'($urandom));
    for (int i = 0; i < 5; i++) send_palette(extra_idx[i], 24'($urandom));
    drain();
    // Line store bytes read later: planes 0 to 2, positions 0 to 3
    write_config(4, 32, 2, MODE_PLN4);
    send_byte(8'hFF);
    send_byte(8'($urandom));
    drain();

    // Directed: byte extremes, zero count, marker-valued run
    write_config(4, 3, 20, MODE_PAL8);
    send_palette(8'h00, 24'h000000);
    send_palette(8'hFF, 24'hFFFFFF);
    send_byte(8'h00);
    send_byte(8'hBF);
    send_byte(8'h3F);
    send_byte(8'hC0);
    send_byte(8'h55);
    send_byte(8'hC3);
    send_byte(8'hFF);
    send_palette(8'h80, 24'h123456);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h12);
    send_byte(8'h01);
    send_byte(8'hC2);
    send_byte(8'h07);
    drain();

    // Random phases across modes and register extremes
    write_config(1, 1, 300, MODE_PAL8);
    random_items(12, 1);
    drain();
    write_config(3, 20, 700, MODE_RGB8);
    hold_req = 1;
    random_items(12, 0);
    drain();
    write_config(2, 13, 1100, MODE_PLN4);
    random_items(12, 0);
    drain();
    write_config(5, 40, 1500, MODE_MONO1);
    random_items(12, 0);
    drain();
    write_config(1024, 8192, 65536, MODE_MONO1);
    random_items(12, 0);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
